### hw/rtl/x86af_pkg.sv
// Package: request/result types, opcodes and width helpers for the x86 ALU with flags
`timescale 1ns / 1ps
`default_nettype none
package x86af_pkg;

  localparam logic [4:0] CMD_ADD  = 5'd0;
  localparam logic [4:0] CMD_ADC  = 5'd1;
  localparam logic [4:0] CMD_INC  = 5'd2;
  localparam logic [4:0] CMD_SUB  = 5'd3;
  localparam logic [4:0] CMD_CMP  = 5'd4;
  localparam logic [4:0] CMD_SBB  = 5'd5;
  localparam logic [4:0] CMD_DEC  = 5'd6;
  localparam logic [4:0] CMD_NEG  = 5'd7;
  localparam logic [4:0] CMD_AND  = 5'd8;
  localparam logic [4:0] CMD_TEST = 5'd9;
  localparam logic [4:0] CMD_OR   = 5'd10;
  localparam logic [4:0] CMD_XOR  = 5'd11;
  localparam logic [4:0] CMD_NOT  = 5'd12;
  localparam logic [4:0] CMD_SHL  = 5'd13;
  localparam logic [4:0] CMD_SHR  = 5'd14;
  localparam logic [4:0] CMD_SAR  = 5'd15;
  localparam logic [4:0] CMD_MUL  = 5'd16;
  localparam logic [4:0] CMD_IMUL = 5'd17;
  localparam logic [4:0] CMD_DIV  = 5'd18;
  localparam logic [4:0] CMD_IDIV = 5'd19;

  localparam logic [1:0] WC_BYTE  = 2'd0;
  localparam logic [1:0] WC_WORD  = 2'd1;
  localparam logic [1:0] WC_DWORD = 2'd2;
  localparam logic [1:0] WC_QWORD = 2'd3;

  localparam int FL_CF = 0;
  localparam int FL_PF = 2;
  localparam int FL_AF = 4;
  localparam int FL_ZF = 6;
  localparam int FL_SF = 7;
  localparam int FL_OF = 11;

  localparam int DIV_STAGES = 64;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [1:0]  width_code;
    logic [63:0] flags_word;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [63:0] flags_out;
    logic        status_code;
  } rsp_t;

  typedef struct packed {
    logic [63:0] res;
    logic [63:0] flags;
  } resf_t;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [1:0]  wc;
    logic [63:0] a;
    logic [63:0] fi;
    logic        qneg;
    logic        dz;
    resf_t       rf;
  } stage_t;

  function automatic logic [63:0] wmask(input logic [1:0] wc);
    logic [63:0] m;
    unique case (wc)
      WC_BYTE:  m = 64'hFF;
      WC_WORD:  m = 64'hFFFF;
      WC_DWORD: m = 64'hFFFF_FFFF;
      default:  m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sbit(input logic [1:0] wc);
    logic [63:0] s;
    unique case (wc)
      WC_BYTE:  s = 64'h80;
      WC_WORD:  s = 64'h8000;
      WC_DWORD: s = 64'h8000_0000;
      default:  s = 64'h8000_0000_0000_0000;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/x86af_simple.sv
// Combinational add, subtract, logic and shift unit with flag update
`timescale 1ns / 1ps
`default_nettype none
module x86af_simple (
  input  wire logic [4:0]  cmd,
  input  wire logic [1:0]  wc,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] fi,
  output x86af_pkg::resf_t rf
);
  import x86af_pkg::*;

  logic [63:0]  mask, sb, bb, r, se;
  logic [5:0]   cnt;
  logic [64:0]  s65, d65;
  logic [127:0] wide;
  logic         c, cf;

  always_comb begin
    mask = wmask(wc);
    sb   = sbit(wc);
    cnt  = (wc == WC_QWORD) ? b[5:0] : {1'b0, b[4:0]};
    rf.res   = a;
    rf.flags = fi;
    bb   = 64'd0;
    c    = 1'b0;
    r    = 64'd0;
    cf   = 1'b0;
    s65  = '0;
    d65  = '0;
    wide = '0;
    se   = a | ((|(a & sb)) ? ~mask : 64'd0);
    unique case (cmd)
      CMD_ADD, CMD_ADC, CMD_INC: begin
        bb  = (cmd == CMD_INC) ? 64'd1 : b;
        c   = (cmd == CMD_ADC) ? fi[FL_CF] : 1'b0;
        s65 = {1'b0, a} + {1'b0, bb} + {64'd0, c};
        r   = s65[63:0] & mask;
        unique case (wc)
          WC_BYTE:  cf = s65[8];
          WC_WORD:  cf = s65[16];
          WC_DWORD: cf = s65[32];
          default:  cf = s65[64];
        endcase
        rf.res = r;
        rf.flags[FL_ZF] = (r == 64'd0);
        rf.flags[FL_SF] = |(r & sb);
        rf.flags[FL_PF] = ~^r[7:0];
        if (cmd != CMD_INC) rf.flags[FL_CF] = cf;
        rf.flags[FL_AF] = a[4] ^ bb[4] ^ r[4];
        rf.flags[FL_OF] = |(~(a ^ bb) & (a ^ r) & sb);
      end
      CMD_SUB, CMD_CMP, CMD_SBB, CMD_DEC: begin
        bb  = (cmd == CMD_DEC) ? 64'd1 : b;
        c   = (cmd == CMD_SBB) ? fi[FL_CF] : 1'b0;
        d65 = {1'b0, a} - {1'b0, bb} - {64'd0, c};
        r   = d65[63:0] & mask;
        rf.res = (cmd == CMD_CMP) ? a : r;
        rf.flags[FL_ZF] = (r == 64'd0);
        rf.flags[FL_SF] = |(r & sb);
        rf.flags[FL_PF] = ~^r[7:0];
        if (cmd != CMD_DEC) rf.flags[FL_CF] = d65[64];
        rf.flags[FL_AF] = a[4] ^ bb[4] ^ r[4];
        rf.flags[FL_OF] = |((a ^ bb) & (a ^ r) & sb);
      end
      CMD_NEG: begin
        r = (64'd0 - a) & mask;
        rf.res = r;
        rf.flags[FL_ZF] = (r == 64'd0);
        rf.flags[FL_SF] = |(r & sb);
        rf.flags[FL_PF] = ~^r[7:0];
        rf.flags[FL_CF] = (a != 64'd0);
        rf.flags[FL_AF] = a[4] ^ r[4];
        rf.flags[FL_OF] = (a == sb);
      end
      CMD_AND, CMD_TEST, CMD_OR, CMD_XOR: begin
        if (cmd == CMD_OR) r = a | b;
        else if (cmd == CMD_XOR) r = a ^ b;
        else r = a & b;
        rf.res = (cmd == CMD_TEST) ? a : r;
        rf.flags[FL_ZF] = (r == 64'd0);
        rf.flags[FL_SF] = |(r & sb);
        rf.flags[FL_PF] = ~^r[7:0];
        rf.flags[FL_CF] = 1'b0;
        rf.flags[FL_AF] = 1'b0;
        rf.flags[FL_OF] = 1'b0;
      end
      CMD_NOT: rf.res = ~a & mask;
      CMD_SHL: begin
        if (cnt != 6'd0) begin
          wide = {64'd0, a} << cnt;
          r    = wide[63:0] & mask;
          unique case (wc)
            WC_BYTE:  cf = wide[8];
            WC_WORD:  cf = wide[16];
            WC_DWORD: cf = wide[32];
            default:  cf = wide[64];
          endcase
          rf.res = r;
          rf.flags[FL_ZF] = (r == 64'd0);
          rf.flags[FL_SF] = |(r & sb);
          rf.flags[FL_PF] = ~^r[7:0];
          rf.flags[FL_CF] = cf;
          if (cnt == 6'd1) rf.flags[FL_OF] = (|(r & sb)) ^ cf;
        end
      end
      CMD_SHR: begin
        if (cnt != 6'd0) begin
          r = a >> cnt;
          rf.res = r;
          rf.flags[FL_ZF] = (r == 64'd0);
          rf.flags[FL_SF] = |(r & sb);
          rf.flags[FL_PF] = ~^r[7:0];
          rf.flags[FL_CF] = a[cnt - 6'd1];
          if (cnt == 6'd1) rf.flags[FL_OF] = |(a & sb);
        end
      end
      CMD_SAR: begin
        if (cnt != 6'd0) begin
          r = 64'($signed(se) >>> cnt) & mask;
          rf.res = r;
          rf.flags[FL_ZF] = (r == 64'd0);
          rf.flags[FL_SF] = |(r & sb);
          rf.flags[FL_PF] = ~^r[7:0];
          rf.flags[FL_CF] = se[cnt - 6'd1];
          if (cnt == 6'd1) rf.flags[FL_OF] = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/x86af_mul.sv
// Pipelined 64x64 multiplier from 32x32 partial products with CF/OF overflow
`timescale 1ns / 1ps
`default_nettype none
module x86af_mul (
  input  wire logic        clk,
  input  wire logic [4:0]  cmd,
  input  wire logic [1:0]  wc,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] fi,
  output x86af_pkg::resf_t rf
);
  import x86af_pkg::*;

  logic [63:0]  p00_r, p01_r, p10_r, p11_r, corr1_r, corr2_r;
  logic [63:0]  fi1_r, fi2_r;
  logic [1:0]   wc1_r, wc2_r;
  logic         im1_r, im2_r;
  logic [127:0] prod2_r;
  logic [63:0]  hi, lo, mask, hs;
  logic         ov;

  always_ff @(posedge clk) begin
    p00_r   <= a[31:0] * b[31:0];
    p01_r   <= a[31:0] * b[63:32];
    p10_r   <= a[63:32] * b[31:0];
    p11_r   <= a[63:32] * b[63:32];
    corr1_r <= ((|(a & sbit(wc))) ? b : 64'd0) + ((|(b & sbit(wc))) ? a : 64'd0);
    fi1_r   <= fi;
    wc1_r   <= wc;
    im1_r   <= (cmd == CMD_IMUL);
    prod2_r <= {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
               + {p11_r, 64'd0};
    corr2_r <= corr1_r;
    fi2_r   <= fi1_r;
    wc2_r   <= wc1_r;
    im2_r   <= im1_r;
  end

  always_comb begin
    mask = wmask(wc2_r);
    lo   = prod2_r[63:0] & mask;
    unique case (wc2_r)
      WC_BYTE:  hi = prod2_r[71:8];
      WC_WORD:  hi = prod2_r[79:16];
      WC_DWORD: hi = prod2_r[95:32];
      default:  hi = prod2_r[127:64];
    endcase
    hs = (hi - corr2_r) & mask;
    if (im2_r) ov = (hs != ((|(lo & sbit(wc2_r))) ? mask : 64'd0));
    else ov = ((hi & mask) != 64'd0);
    rf.res = lo;
    rf.flags = fi2_r;
    rf.flags[FL_CF] = ov;
    rf.flags[FL_OF] = ov;
  end

endmodule
`default_nettype wire

### hw/rtl/x86af_div.sv
// Pipelined restoring divider: one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module x86af_div (
  input  wire logic        clk,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic [63:0]      quo
);
  import x86af_pkg::*;

  logic [63:0] rem_r [0:DIV_STAGES];
  logic [63:0] nq_r  [0:DIV_STAGES];
  logic [63:0] den_r [0:DIV_STAGES];

  always_comb begin
    rem_r[0] = 64'd0;
    nq_r[0]  = num;
    den_r[0] = den;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [64:0] trial, diff;
    always_comb begin
      trial = {rem_r[k], nq_r[k][63]};
      diff  = trial - {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      den_r[k+1] <= den_r[k];
      if (!diff[64]) begin
        rem_r[k+1] <= diff[63:0];
        nq_r[k+1]  <= {nq_r[k][62:0], 1'b1};
      end else begin
        rem_r[k+1] <= trial[63:0];
        nq_r[k+1]  <= {nq_r[k][62:0], 1'b0};
      end
    end
  end

  assign quo = nq_r[DIV_STAGES];

endmodule
`default_nettype wire

### hw/rtl/x86_alu_with_flags_core.sv
// Top level: x86 integer ALU with flags, pipelined
// Every operation, divide or not, runs the full pipeline from start to out_valid.
// Throughput: one request per cycle; busy is never raised.
// Latency is set by the 64-stage divider, one quotient bit per stage.
// Reset clears the valid bits only; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module x86_alu_with_flags_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire x86af_pkg::req_t  in_data,
  output logic                  out_valid,
  output x86af_pkg::rsp_t       out_data
);
  import x86af_pkg::*;

  localparam int LAST = DIV_STAGES;

  logic        s0_vld_r;
  logic [4:0]  s0_cmd_r;
  logic [1:0]  s0_wc_r;
  logic [63:0] s0_a_r, s0_b_r, s0_fi_r, s0_ma_r, s0_mb_r;
  logic        s0_qneg_r, s0_dz_r;

  logic        vld_r  [1:LAST];
  stage_t      pipe_r [1:LAST];
  stage_t      pipe3_nxt;
  resf_t       simple_rf, mul_rf;
  logic [63:0] quo, qv;
  logic        out_valid_r;
  rsp_t        out_data_r, out_data_nxt;

  logic [63:0] m_in, am, bm, sa, sbv;

  assign busy = 1'b0;

  always_comb begin
    m_in = wmask(in_data.width_code);
    am   = in_data.operand_a & m_in;
    bm   = in_data.operand_b & m_in;
    sa   = am | ((|(am & sbit(in_data.width_code))) ? ~m_in : 64'd0);
    sbv  = bm | ((|(bm & sbit(in_data.width_code))) ? ~m_in : 64'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else s0_vld_r <= start && !busy;
    s0_cmd_r  <= in_data.cmd;
    s0_wc_r   <= in_data.width_code;
    s0_a_r    <= am;
    s0_b_r    <= bm;
    s0_fi_r   <= in_data.flags_word;
    s0_dz_r   <= (bm == 64'd0);
    if (in_data.cmd == CMD_IDIV) begin
      s0_ma_r   <= sa[63] ? (64'd0 - sa) : sa;
      s0_mb_r   <= sbv[63] ? (64'd0 - sbv) : sbv;
      s0_qneg_r <= sa[63] ^ sbv[63];
    end else begin
      s0_ma_r   <= am;
      s0_mb_r   <= bm;
      s0_qneg_r <= 1'b0;
    end
  end

  x86af_simple u_simple (
    .cmd (s0_cmd_r),
    .wc  (s0_wc_r),
    .a   (s0_a_r),
    .b   (s0_b_r),
    .fi  (s0_fi_r),
    .rf  (simple_rf)
  );

  x86af_mul u_mul (
    .clk (clk),
    .cmd (s0_cmd_r),
    .wc  (s0_wc_r),
    .a   (s0_a_r),
    .b   (s0_b_r),
    .fi  (s0_fi_r),
    .rf  (mul_rf)
  );

  x86af_div u_div (
    .clk (clk),
    .num (s0_ma_r),
    .den (s0_mb_r),
    .quo (quo)
  );

  always_comb begin
    pipe3_nxt = pipe_r[2];
    if (pipe_r[2].cmd == CMD_MUL || pipe_r[2].cmd == CMD_IMUL) pipe3_nxt.rf = mul_rf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= s0_vld_r;
      for (int k = 2; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
    pipe_r[1] <= '{cmd: s0_cmd_r, wc: s0_wc_r, a: s0_a_r, fi: s0_fi_r,
                   qneg: s0_qneg_r, dz: s0_dz_r, rf: simple_rf};
    pipe_r[2] <= pipe_r[1];
    pipe_r[3] <= pipe3_nxt;
    for (int k = 4; k <= LAST; k++) pipe_r[k] <= pipe_r[k-1];
  end

  always_comb begin
    qv = pipe_r[LAST].qneg ? (64'd0 - quo) : quo;
    out_data_nxt.result_value = pipe_r[LAST].rf.res;
    out_data_nxt.flags_out    = pipe_r[LAST].rf.flags;
    out_data_nxt.status_code  = 1'b0;
    if (pipe_r[LAST].cmd == CMD_DIV || pipe_r[LAST].cmd == CMD_IDIV) begin
      out_data_nxt.flags_out = pipe_r[LAST].fi;
      if (pipe_r[LAST].dz) begin
        out_data_nxt.result_value = pipe_r[LAST].a;
        out_data_nxt.status_code  = 1'b1;
      end else begin
        out_data_nxt.result_value = qv & wmask(pipe_r[LAST].wc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vld_r[LAST];
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] |=> out_valid)
    else $error("result strobe lost");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[LAST] |=> !out_valid)
    else $error("spurious result strobe");

  a_status_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status_code |->
      ($past(pipe_r[LAST].cmd) == CMD_DIV || $past(pipe_r[LAST].cmd) == CMD_IDIV))
    else $error("divide error on non-divide request");

endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for the x86 ALU with flags: random and directed requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import x86af_pkg::*;

  localparam int LATENCY   = 66;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 700;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  req_t   in_data = '0;
  logic   out_valid;
  rsp_t   out_data;
  logic   busy_q = 1'b0;

  req_t   pending_reqs[$];
  rsp_t   expected_rsps[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;

  x86_alu_with_flags_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit even_par(logic [63:0] v);
    return ~^v[7:0];
  endfunction

  function automatic logic [63:0] set_szp(logic [63:0] f, logic [63:0] r, logic [63:0] sb);
    f[FL_ZF] = (r == 64'd0);
    f[FL_SF] = ((r & sb) != 64'd0);
    f[FL_PF] = even_par(r);
    return f;
  endfunction

  function automatic logic [63:0] sx(logic [63:0] v, logic [63:0] m, logic [63:0] sb);
    v &= m;
    return ((v & sb) != 0) ? (v | ~m) : v;
  endfunction

  function automatic rsp_t alu_predict(req_t rq);
    rsp_t         rs;
    logic [63:0]  m, sb, a, b, fi, f, res, bb, r, c, se, sa, sbv, q, rx;
    logic [64:0]  t;
    logic [127:0] p;
    logic signed [127:0] sp;
    int           bits, cnt;
    bit           cf, ov;
    m   = wmask(rq.width_code);
    sb  = sbit(rq.width_code);
    bits = 8 << rq.width_code;
    a   = rq.operand_a & m;
    b   = rq.operand_b & m;
    fi  = rq.flags_word;
    f   = fi;
    res = a;
    rs.status_code = 1'b0;
    cnt = int'(b & ((rq.width_code == WC_QWORD) ? 64'h3F : 64'h1F));
    case (rq.cmd)
      CMD_ADD, CMD_ADC, CMD_INC: begin
        bb = (rq.cmd == CMD_INC) ? 64'd1 : b;
        c  = (rq.cmd == CMD_ADC) ? {63'd0, fi[FL_CF]} : 64'd0;
        t  = {1'b0, a} + {1'b0, bb} + {1'b0, c};
        r  = t[63:0] & m;
        cf = (rq.width_code == WC_QWORD) ? t[64] : t[bits];
        f  = set_szp(fi, r, sb);
        if (rq.cmd != CMD_INC) f[FL_CF] = cf;
        f[FL_AF] = ((a ^ bb ^ r) & 64'h10) != 0;
        f[FL_OF] = ((~(a ^ bb) & (a ^ r)) & sb) != 0;
        res = r;
      end
      CMD_SUB, CMD_CMP, CMD_SBB, CMD_DEC: begin
        bb = (rq.cmd == CMD_DEC) ? 64'd1 : b;
        c  = (rq.cmd == CMD_SBB) ? {63'd0, fi[FL_CF]} : 64'd0;
        r  = (a - bb - c) & m;
        cf = (a < bb) || ((a - bb) < c);
        f  = set_szp(fi, r, sb);
        if (rq.cmd != CMD_DEC) f[FL_CF] = cf;
        f[FL_AF] = ((a ^ bb ^ r) & 64'h10) != 0;
        f[FL_OF] = (((a ^ bb) & (a ^ r)) & sb) != 0;
        res = (rq.cmd == CMD_CMP) ? a : r;
      end
      CMD_NEG: begin
        r = (64'd0 - a) & m;
        f = set_szp(fi, r, sb);
        f[FL_CF] = (a != 0);
        f[FL_AF] = ((a ^ r) & 64'h10) != 0;
        f[FL_OF] = (a == sb);
        res = r;
      end
      CMD_AND, CMD_TEST, CMD_OR, CMD_XOR: begin
        r = (rq.cmd == CMD_OR) ? (a | b) : (rq.cmd == CMD_XOR) ? (a ^ b) : (a & b);
        f = set_szp(fi, r, sb);
        f[FL_CF] = 1'b0;
        f[FL_OF] = 1'b0;
        f[FL_AF] = 1'b0;
        res = (rq.cmd == CMD_TEST) ? a : r;
      end
      CMD_NOT: res = ~a & m;
      CMD_SHL: if (cnt != 0) begin
        res = (a << cnt) & m;
        cf  = (cnt <= bits) ? a[bits - cnt] : 1'b0;
        f   = set_szp(fi, res, sb);
        f[FL_CF] = cf;
        if (cnt == 1) f[FL_OF] = ((res & sb) != 0) ^ cf;
      end
      CMD_SHR: if (cnt != 0) begin
        res = a >> cnt;
        f   = set_szp(fi, res, sb);
        f[FL_CF] = a[cnt - 1];
        if (cnt == 1) f[FL_OF] = (a & sb) != 0;
      end
      CMD_SAR: if (cnt != 0) begin
        se  = sx(a, m, sb);
        res = (se >>> cnt) & m;
        res = $unsigned($signed(se) >>> cnt) & m;
        f   = set_szp(fi, res, sb);
        f[FL_CF] = se[cnt - 1];
        if (cnt == 1) f[FL_OF] = 1'b0;
      end
      CMD_MUL: begin
        p   = {64'd0, a} * {64'd0, b};
        res = p[63:0] & m;
        ov  = (p >> bits) != 0;
        f[FL_CF] = ov;
        f[FL_OF] = ov;
      end
      CMD_IMUL: begin
        sa  = sx(a, m, sb);
        sbv = sx(b, m, sb);
        sp  = $signed({{64{sa[63]}}, sa}) * $signed({{64{sbv[63]}}, sbv});
        res = sp[63:0] & m;
        rx  = sx(res, m, sb);
        ov  = sp != {{64{rx[63]}}, rx};
        f[FL_CF] = ov;
        f[FL_OF] = ov;
      end
      CMD_DIV: begin
        if (b == 0) rs.status_code = 1'b1;
        else res = (a / b) & m;
      end
      CMD_IDIV: begin
        if (b == 0) rs.status_code = 1'b1;
        else begin
          sa  = sx(a, m, sb);
          sbv = sx(b, m, sb);
          q   = (sa[63] ? -sa : sa) / (sbv[63] ? -sbv : sbv);
          if (sa[63] != sbv[63]) q = -q;
          res = q & m;
        end
      end
      default: ;
    endcase
    rs.result_value = res;
    rs.flags_out    = f;
    return rs;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'd1 << $urandom_range(0, 63);
      3: v = v & 64'hFF;
      4: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 63'd0};
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_req(logic [4:0] cmd, logic [63:0] a, logic [63:0] b,
                           logic [1:0] wc, logic [63:0] fl);
    req_t rq;
    rq.cmd = cmd;
    rq.operand_a = a;
    rq.operand_b = b;
    rq.width_code = wc;
    rq.flags_word = fl;
    pending_reqs.push_back(rq);
  endtask

  initial begin
    logic [4:0] cmd;
    logic [1:0] wc;
    logic [63:0] b;
    for (int w = 0; w < 4; w++) begin
      queue_req(CMD_ADD, '1, 64'd1, 2'(w), 64'd0);
      queue_req(CMD_IDIV, sbit(2'(w)), '1, 2'(w), '1);
      queue_req(CMD_IMUL, sbit(2'(w)), '1, 2'(w), 64'd0);
    end
    queue_req(CMD_DIV, 64'd5, 64'h100, WC_BYTE, 64'hFFF);
    queue_req(CMD_IDIV, 64'd7, 64'd0, WC_QWORD, 64'd0);
    queue_req(CMD_SHL, 64'h1, 64'd20, WC_BYTE, '1);
    queue_req(CMD_SHL, 64'hFF, 64'd0, WC_WORD, 64'h55);
    queue_req(CMD_SHL, 64'h81, 64'd1, WC_BYTE, 64'd0);
    queue_req(CMD_SHR, 64'h8000_0000_0000_0001, 64'd1, WC_QWORD, 64'd0);
    queue_req(CMD_SAR, 64'h80, 64'd1, WC_BYTE, '1);
    queue_req(CMD_NEG, 64'h80, 64'd0, WC_BYTE, 64'd0);
    queue_req(CMD_SBB, 64'd0, '1, WC_QWORD, 64'd1);
    queue_req(CMD_ADC, '1, '1, WC_QWORD, 64'd1);
    queue_req(CMD_MUL, '1, '1, WC_QWORD, 64'd0);
    queue_req(5'd31, '1, '1, WC_QWORD, '1);
    queue_req(CMD_NOT, 64'd0, 64'd0, WC_DWORD, '1);
    for (int i = 0; i < N_RANDOM; i++) begin
      cmd = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 9) != 0) cmd = 5'($urandom_range(0, 19));
      wc = 2'($urandom_range(0, 3));
      b = rand64();
      if ((cmd >= CMD_SHL && cmd <= CMD_SAR) && $urandom_range(0, 1))
        b = (b & ~64'h3F) | 64'($urandom_range(0, 65));
      queue_req(cmd, rand64(), b, wc, {$urandom(), $urandom()});
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_q) begin
        expected_rsps.push_back(alu_predict(in_data));
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0 && !(start && busy_q)) begin
        gap_left--;
        start <= 1'b0;
      end else if (start && busy_q) begin
        start <= 1'b1;
      end else if (pending_reqs.size() > 0) begin
        burst_left--;
        in_data <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) busy_q <= busy;

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result %h", out_data);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data.result_value !== exp_rsp.result_value) begin
            $error("result_value exp %h got %h", exp_rsp.result_value, out_data.result_value);
            errors++;
          end
          if (out_data.flags_out !== exp_rsp.flags_out) begin
            $error("flags_out exp %h got %h", exp_rsp.flags_out, out_data.flags_out);
            errors++;
          end
          if (out_data.status_code !== exp_rsp.status_code) begin
            $error("status_code exp %h got %h", exp_rsp.status_code, out_data.status_code);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done || idle_cycles >= WDOG_MAX);
    while (expected_rsps.size() > 0 && idle_cycles < WDOG_MAX) @(posedge clk);
    if (idle_cycles >= WDOG_MAX) begin
      $display("TEST FAILED");
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      if (errors == 0 && expected_rsps.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/x86af_pkg.sv
hw/rtl/x86af_simple.sv
hw/rtl/x86af_mul.sv
hw/rtl/x86af_div.sv
hw/rtl/x86_alu_with_flags_core.sv
dv/testbench.sv
